// ===== rtl/core/utse_pkg.sv =====
`timescale 1ns / 1ps
// Package for the UTF-16 text save encoder: mode codes, queue entry type
// and the byte-sequence helper functions. No dependencies.
package utse_pkg;

  localparam logic [1:0] MODE_UTF8     = 2'd0;
  localparam logic [1:0] MODE_UTF8_BOM = 2'd1;
  localparam logic [1:0] MODE_UTF16LE  = 2'd2;
  localparam logic [1:0] MODE_UTF16BE  = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_BYTES   = 6;

  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;
  localparam logic [20:0] MAX_1BYTE       = 21'h7F;
  localparam logic [20:0] MAX_2BYTE       = 21'h7FF;
  localparam logic [20:0] MAX_3BYTE       = 21'hFFFF;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;
  localparam logic [7:0] BOM8_0  = 8'hEF;
  localparam logic [7:0] BOM8_1  = 8'hBB;
  localparam logic [7:0] BOM8_2  = 8'hBF;
  localparam logic [7:0] BOM_FF  = 8'hFF;
  localparam logic [7:0] BOM_FE  = 8'hFE;

  // Up to four bytes, b[0] first in file order.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } seg_t;

  // Byte collector used while one word is classified.
  typedef struct packed {
    logic [7:0][7:0] b;
    logic [3:0]      n;
  } acc_t;

  // One queue entry: the bytes one input word causes.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } entry_t;

  function automatic seg_t utf8_seg(input logic [20:0] cp);
    seg_t s;
    s = '0;
    if (cp <= MAX_1BYTE) begin
      s.b[0] = cp[7:0];
      s.len  = 3'd1;
    end else if (cp <= MAX_2BYTE) begin
      s.b[0] = LEAD2 | {3'b000, cp[10:6]};
      s.b[1] = CONT | {2'b00, cp[5:0]};
      s.len  = 3'd2;
    end else if (cp <= MAX_3BYTE) begin
      s.b[0] = LEAD3 | {4'b0000, cp[15:12]};
      s.b[1] = CONT | {2'b00, cp[11:6]};
      s.b[2] = CONT | {2'b00, cp[5:0]};
      s.len  = 3'd3;
    end else begin
      s.b[0] = LEAD4 | {5'b00000, cp[20:18]};
      s.b[1] = CONT | {2'b00, cp[17:12]};
      s.b[2] = CONT | {2'b00, cp[11:6]};
      s.b[3] = CONT | {2'b00, cp[5:0]};
      s.len  = 3'd4;
    end
    return s;
  endfunction

  function automatic seg_t utf16_seg(input logic [15:0] unit, input logic [1:0] mode);
    seg_t s;
    s = '0;
    if (mode == MODE_UTF16BE) begin
      s.b[0] = unit[15:8];
      s.b[1] = unit[7:0];
    end else begin
      s.b[0] = unit[7:0];
      s.b[1] = unit[15:8];
    end
    s.len = 3'd2;
    return s;
  endfunction

  // A held unit goes out in whatever mode is current.
  function automatic seg_t held_seg(input logic [15:0] unit, input logic [1:0] mode);
    seg_t s;
    if (mode inside {MODE_UTF16LE, MODE_UTF16BE}) s = utf16_seg(unit, mode);
    else s = utf8_seg({5'b00000, unit});
    return s;
  endfunction

  function automatic acc_t append(input acc_t a, input seg_t s);
    acc_t       r;
    logic [3:0] pos;
    r = a;
    for (int i = 0; i < 4; i++) begin
      pos = r.n + 4'(i);
      if (3'(i) < s.len && pos < 4'd8) r.b[pos[2:0]] = s.b[i];
    end
    r.n = r.n + {1'b0, s.len};
    return r;
  endfunction

endpackage

// ===== rtl/core/utse_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the UTF-16 text save encoder:
// the code unit input channel and the byte output channel.
interface utse_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_present;
  logic        end_of_text;

  modport source (output valid, code_unit, unit_present, end_of_text, input ready);
  modport sink   (input valid, code_unit, unit_present, end_of_text, output ready);
endinterface

interface utse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// ===== rtl/core/utf16_text_save_encoder_top.sv =====
`timescale 1ns / 1ps
// UTF-16 text save encoder, top level. Instantiates utse_front, utse_queue,
// utse_back; uses utse_pkg and the channel interfaces in utse_if.
//
// Takes one 16-bit UTF-16 code unit word per accepted handshake and sends the
// file bytes it causes, one byte word per cycle, in UTF-8, UTF-8 with mark,
// UTF-16 LE or UTF-16 BE (set by encoding_mode through cfg_we/cfg_wdata; the
// user must write it only while idle, the block does not enforce this). The
// input side takes a word every cycle while the entry queue has room; the
// output side sends one byte per cycle while the receiver does not stall, so
// a word goes out through the one-byte-wide output register as 0 to 6 byte
// words, 1 to 3 for ordinary text. A word that produces bytes reaches the
// output through the queue entry written at the accepting edge, then the
// unload register, then the output register.
module utf16_text_save_encoder_top #(
  parameter int QueueDepth = utse_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  utse_in_if.sink    in_ch,
  utse_out_if.source out_ch
);

  logic [1:0]       encoding_mode;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  utse_pkg::entry_t push_entry;
  utse_pkg::entry_t pop_entry;

  // mode register, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= utse_pkg::MODE_UTF8;
    end else if (cfg_we) begin
      encoding_mode <= cfg_wdata;
    end
  end

  // classify words, track held surrogate and document start
  utse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (encoding_mode),
    .in_ch      (in_ch),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples word intake from byte output
  utse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  // serialize entries to byte words
  utse_back u_back (
    .clk    (clk),
    .rst    (rst),
    .entry  (pop_entry),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/utse_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts code unit words, tracks surrogate and document state,
// and turns each word into a queue entry of 0..6 bytes. Uses utse_pkg, utse_if.
module utse_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           mode,
  utse_in_if.sink              in_ch,
  input  logic                 full,
  output logic                 push,
  output utse_pkg::entry_t     push_entry
);

  logic [15:0]     held;
  logic            held_valid;
  logic            at_start;
  logic [15:0]     held_next;
  logic            held_valid_next;
  logic            at_start_next;
  utse_pkg::acc_t  acc;
  logic            accept;
  logic            is_low;
  logic            is_high;
  logic            is16;
  logic            active;
  logic [20:0]     cp;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    acc             = '0;
    held_next       = held;
    held_valid_next = held_valid;
    at_start_next   = at_start;
    active  = in_ch.unit_present || in_ch.end_of_text;
    is16    = mode inside {utse_pkg::MODE_UTF16LE, utse_pkg::MODE_UTF16BE};
    is_low  = in_ch.code_unit inside {[utse_pkg::LOW_SURR_FIRST:utse_pkg::LOW_SURR_LAST]};
    is_high = in_ch.code_unit inside {[utse_pkg::HIGH_SURR_FIRST:utse_pkg::HIGH_SURR_LAST]};
    cp      = utse_pkg::SUPP_BASE + {1'b0, held[9:0], in_ch.code_unit[9:0]};

    // byte order mark at the start of a document
    if (active && at_start) begin
      case (mode)
        utse_pkg::MODE_UTF8_BOM: begin
          acc.b[0] = utse_pkg::BOM8_0;
          acc.b[1] = utse_pkg::BOM8_1;
          acc.b[2] = utse_pkg::BOM8_2;
          acc.n    = 4'd3;
        end
        utse_pkg::MODE_UTF16LE: begin
          acc.b[0] = utse_pkg::BOM_FF;
          acc.b[1] = utse_pkg::BOM_FE;
          acc.n    = 4'd2;
        end
        utse_pkg::MODE_UTF16BE: begin
          acc.b[0] = utse_pkg::BOM_FE;
          acc.b[1] = utse_pkg::BOM_FF;
          acc.n    = 4'd2;
        end
        default: acc.n = 4'd0;
      endcase
    end

    if (in_ch.unit_present) begin
      if (is16) begin
        if (held_valid) acc = utse_pkg::append(acc, utse_pkg::utf16_seg(held, mode));
        acc = utse_pkg::append(acc, utse_pkg::utf16_seg(in_ch.code_unit, mode));
        held_valid_next = 1'b0;
        held_next       = '0;
      end else if (held_valid && is_low) begin
        acc = utse_pkg::append(acc, utse_pkg::utf8_seg(cp));
        held_valid_next = 1'b0;
        held_next       = '0;
      end else begin
        if (held_valid) acc = utse_pkg::append(acc, utse_pkg::utf8_seg({5'b00000, held}));
        held_valid_next = 1'b0;
        held_next       = '0;
        if (is_high) begin
          held_valid_next = 1'b1;
          held_next       = in_ch.code_unit;
        end else begin
          acc = utse_pkg::append(acc, utse_pkg::utf8_seg({5'b00000, in_ch.code_unit}));
        end
      end
    end

    if (in_ch.end_of_text) begin
      if (held_valid_next) acc = utse_pkg::append(acc, utse_pkg::held_seg(held_next, mode));
      held_valid_next = 1'b0;
      held_next       = '0;
      at_start_next   = 1'b1;
    end else if (active) begin
      at_start_next = 1'b0;
    end
  end

  assign push             = accept && (acc.n != 4'd0);
  assign push_entry.bytes = acc.b[utse_pkg::MAX_BYTES-1:0];
  assign push_entry.cnt   = (acc.n > 4'(utse_pkg::MAX_BYTES)) ? 3'(utse_pkg::MAX_BYTES)
                                                              : acc.n[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      held_valid <= 1'b0;
      at_start   <= 1'b1;
    end else if (accept) begin
      held       <= held_next;
      held_valid <= held_valid_next;
      at_start   <= at_start_next;
    end
  end

endmodule

// ===== rtl/core/utse_queue.sv =====
`timescale 1ns / 1ps
// Short register queue of byte entries between front and back end.
// Uses utse_pkg for the entry type.
module utse_queue #(
  parameter int Depth = utse_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utse_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output utse_pkg::entry_t pop_entry,
  output logic             empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  utse_pkg::entry_t  slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full      = (count == CntW'(Depth));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/utse_back.sv =====
`timescale 1ns / 1ps
// Back end: unloads queue entries and sends their bytes one word per cycle
// unless stalled, via a registered output stage. Uses utse_pkg, utse_if.
module utse_back (
  input  logic             clk,
  input  logic             rst,
  input  utse_pkg::entry_t entry,
  input  logic             empty,
  output logic             pop,
  utse_out_if.source       out_ch
);

  logic [utse_pkg::MAX_BYTES-1:0][7:0] wbytes;
  logic [2:0] wcnt;
  logic [2:0] widx;
  logic       wvalid;
  logic       ovalid;
  logic [7:0] obyte;
  logic       olast;
  logic       load_out;
  logic       wlast;

  assign load_out = wvalid && (!ovalid || out_ch.ready);
  assign wlast    = (widx == wcnt - 3'd1);
  assign pop      = !empty && (!wvalid || (load_out && wlast));

  assign out_ch.valid       = ovalid;
  assign out_ch.out_byte    = obyte;
  assign out_ch.last_of_run = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      wvalid <= 1'b0;
      widx   <= '0;
    end else begin
      if (load_out) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
      // a new entry loads when none is held or the last byte leaves this cycle
      if (pop) begin
        wvalid <= 1'b1;
        widx   <= '0;
      end else if (load_out) begin
        widx <= widx + 3'd1;
        if (wlast) wvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      obyte <= wbytes[widx];
      olast <= wlast;
    end
    if (pop) begin
      wbytes <= entry.bytes;
      wcnt   <= entry.cnt;
    end
  end

endmodule

// ===== rtl/core/utse_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the UTF-16 text save encoder top level, with the
// bind that attaches them. Depends on utf16_text_save_encoder_top.
module utse_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // queue is empty right after reset, so intake is open
  a_ready_after_rst: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // nothing left in the output stage after reset
  a_no_out_after_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed while stalled");

endmodule

bind utf16_text_save_encoder_top utse_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_of_run)
);

// ===== test/utf16_text_save_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf16_text_save_encoder_top: directed and random code unit
// words against an in-bench encoder model. Needs utse_pkg and utse_if from the RTL.
module utf16_text_save_encoder_top_tb;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 12;    // extra wait once all expected bytes are out
  localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either side

  typedef struct {
    logic [7:0] b;
    logic       last;
  } file_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  utse_in_if  in_ch ();
  utse_out_if out_ch ();

  utf16_text_save_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #6 clk = ~clk;

  // Encoder model state, mirrors the block after reset.
  logic [1:0]  cur_mode;
  logic [15:0] held_unit;
  logic        held_ok;
  logic        doc_start;

  // Bytes one word produces, before the six-byte cap.
  logic [7:0]  pend [8];
  int          pend_n;

  file_byte_t  file_bytes_q [$];

  // Idling knobs, percent per cycle.
  int send_idle_pct;
  int recv_stall_pct;

  int errors;
  int words_sent;
  int bytes_seen;
  int docs;
  int idle_cycles;

  // ---------------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------------
  function void put_b(input logic [7:0] v);
    if (pend_n < 8) begin
      pend[pend_n] = v;
      pend_n++;
    end
  endfunction

  function void put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_b(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      put_b(8'hC0 | {3'b000, cp[10:6]});
      put_b(8'h80 | {2'b00, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      put_b(8'hE0 | {4'b0000, cp[15:12]});
      put_b(8'h80 | {2'b00, cp[11:6]});
      put_b(8'h80 | {2'b00, cp[5:0]});
    end else begin
      put_b(8'hF0 | {5'b00000, cp[20:18]});
      put_b(8'h80 | {2'b00, cp[17:12]});
      put_b(8'h80 | {2'b00, cp[11:6]});
      put_b(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  function void put_utf16(input logic [15:0] u);
    if (cur_mode == utse_pkg::MODE_UTF16BE) begin
      put_b(u[15:8]);
      put_b(u[7:0]);
    end else begin
      put_b(u[7:0]);
      put_b(u[15:8]);
    end
  endfunction

  // A held high surrogate leaves in the mode that is current now.
  function void flush_held();
    if (held_ok) begin
      if (cur_mode == utse_pkg::MODE_UTF16LE || cur_mode == utse_pkg::MODE_UTF16BE)
        put_utf16(held_unit);
      else put_utf8({5'b00000, held_unit});
      held_ok   = 1'b0;
      held_unit = '0;
    end
  endfunction

  // Works out the file bytes of one accepted word and queues them.
  function void encode_word(input logic [15:0] cu, input logic pres, input logic eot);
    logic        is_low;
    logic        is_high;
    logic [20:0] cp;
    file_byte_t  fb;
    pend_n = 0;
    if (!pres && !eot) return;   // ignored word: no mark yet, state kept

    if (doc_start) begin
      case (cur_mode)
        utse_pkg::MODE_UTF8_BOM: begin
          put_b(8'hEF); put_b(8'hBB); put_b(8'hBF);
        end
        utse_pkg::MODE_UTF16LE: begin
          put_b(8'hFF); put_b(8'hFE);
        end
        utse_pkg::MODE_UTF16BE: begin
          put_b(8'hFE); put_b(8'hFF);
        end
        default: ;
      endcase
      doc_start = 1'b0;
    end

    if (pres) begin
      if (cur_mode == utse_pkg::MODE_UTF16LE || cur_mode == utse_pkg::MODE_UTF16BE) begin
        flush_held();
        put_utf16(cu);
      end else begin
        is_low  = (cu >= 16'hDC00) && (cu <= 16'hDFFF);
        is_high = (cu >= 16'hD800) && (cu <= 16'hDBFF);
        if (held_ok && is_low) begin
          // pair: 0x10000 + (hi - D800) << 10 | (lo - DC00)
          cp        = 21'h10000 + {1'b0, held_unit[9:0], cu[9:0]};
          held_ok   = 1'b0;
          held_unit = '0;
          put_utf8(cp);
        end else begin
          flush_held();
          if (is_high) begin
            held_unit = cu;
            held_ok   = 1'b1;
          end else begin
            put_utf8({5'b00000, cu});
          end
        end
      end
    end

    if (eot) begin
      flush_held();
      doc_start = 1'b1;
    end

    for (int k = 0; k < pend_n && k < utse_pkg::MAX_BYTES; k++) begin
      fb.b    = pend[k];
      fb.last = (k == pend_n - 1);
      file_bytes_q.insert(file_bytes_q.size(), fb);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls, byte check for each word that moves
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid and ready only change at the rising edge, so sampling at the falling
  // edge sees the pair that the next rising edge acts on.
  always @(negedge clk) begin
    file_byte_t exp_b;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      bytes_seen++;
      if (file_bytes_q.size() == 0) begin
        $error("out_byte: no byte expected, got %h (last_of_run %b)",
               out_ch.out_byte, out_ch.last_of_run);
        errors++;
      end else begin
        exp_b = file_bytes_q.pop_front();
        if (out_ch.out_byte !== exp_b.b) begin
          $error("out_byte: expected %h, got %h", exp_b.b, out_ch.out_byte);
          errors++;
        end
        if (out_ch.last_of_run !== exp_b.last) begin
          $error("last_of_run: expected %b, got %b", exp_b.last, out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends a run in which nothing moves for too long.
  always @(negedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL utf16_text_save_encoder_top");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the word is taken,
  // leaving valid high so a following word can go out back to back.
  task automatic send_word(input logic [15:0] cu, input logic pres, input logic eot);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.code_unit    <= cu;
    in_ch.unit_present <= pres;
    in_ch.end_of_text  <= eot;
    do begin
      @(negedge clk);
      took = (in_ch.ready === 1'b1);
      @(posedge clk);
    end while (!took);
    encode_word(cu, pres, eot);
    words_sent++;
  endtask

  // Every expected byte out, then a further DRAIN_CYCLES wait so a word that
  // made no bytes has surely left the pipe.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (file_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode = m;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Sequence-length boundaries and surrogate pairs in plain UTF-8.
  task automatic test_utf8_ranges();
    set_mode(utse_pkg::MODE_UTF8);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'h007F, 1'b1, 1'b0);
    send_word(16'h0080, 1'b1, 1'b0);
    send_word(16'h07FF, 1'b1, 1'b0);
    send_word(16'h0800, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'hD800, 1'b1, 1'b0);   // held, no bytes
    send_word(16'hDC00, 1'b1, 1'b0);   // U+10000
    send_word(16'hDBFF, 1'b1, 1'b0);
    send_word(16'hDFFF, 1'b1, 1'b1);   // U+10FFFF, document ends
    docs++;
  endtask

  // Lone surrogates, the ignored word and the empty document.
  task automatic test_lone_surrogates();
    send_word(16'hDC00, 1'b1, 1'b0);   // low with nothing held
    send_word(16'hD800, 1'b1, 1'b0);
    send_word(16'h0041, 1'b1, 1'b0);   // high flushed ahead of 'A'
    send_word(16'hFFFF, 1'b0, 1'b0);   // ignored
    send_word(16'hDBFF, 1'b1, 1'b0);
    send_word(16'hD800, 1'b1, 1'b1);   // high over high, flushed at the end
    send_word(16'h0000, 1'b0, 1'b1);   // empty document, no mark in UTF-8
    docs += 2;
  endtask

  // Marks of the three marked modes, for empty and short documents.
  task automatic test_marks();
    set_mode(utse_pkg::MODE_UTF8_BOM);
    send_word(16'h0000, 1'b0, 1'b1);
    send_word(16'h00E9, 1'b1, 1'b1);
    set_mode(utse_pkg::MODE_UTF16LE);
    send_word(16'hD83D, 1'b1, 1'b0);
    send_word(16'hDE00, 1'b1, 1'b1);
    send_word(16'hFFFF, 1'b0, 1'b1);
    set_mode(utse_pkg::MODE_UTF16BE);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b1);
    docs += 5;
  endtask

  // High surrogate held in UTF-8, mode then moved to UTF-16 BE: the held unit
  // goes out as two BE bytes ahead of the next unit.
  task automatic test_held_mode_switch();
    set_mode(utse_pkg::MODE_UTF8);
    send_word(16'hD801, 1'b1, 1'b0);
    set_mode(utse_pkg::MODE_UTF16BE);
    send_word(16'h1234, 1'b1, 1'b1);
    docs++;
  endtask

  // Mostly well-formed documents with random content; some lone surrogates,
  // ignored words and documents left open.
  task automatic test_random_docs(input int n_units);
    logic [15:0] doc [$];
    int          sent;
    int          len;
    int          end_kind;
    logic        sep_end;
    logic        no_end;
    sent = 0;
    while (sent < n_units) begin
      doc.delete();
      len = $urandom_range(0, 7);
      while (doc.size() < len) begin
        case ($urandom_range(0, 11))
          0, 1, 2: doc.insert(doc.size(), 16'($urandom_range(16'h007F, 0)));
          3:       doc.insert(doc.size(), 16'($urandom_range(16'h07FF, 16'h0080)));
          4:       doc.insert(doc.size(), 16'($urandom_range(16'hD7FF, 16'h0800)));
          5:       doc.insert(doc.size(), 16'($urandom_range(16'hFFFF, 16'hE000)));
          6, 7, 8: begin
            doc.insert(doc.size(), 16'($urandom_range(16'hDBFF, 16'hD800)));
            doc.insert(doc.size(), 16'($urandom_range(16'hDFFF, 16'hDC00)));
          end
          9:       doc.insert(doc.size(), 16'($urandom_range(16'hDFFF, 16'hD800)));
          10:      doc.insert(doc.size(), 16'($urandom));
          default: begin
            case ($urandom_range(0, 5))
              0: doc.insert(doc.size(), 16'h0000);
              1: doc.insert(doc.size(), 16'h007F);
              2: doc.insert(doc.size(), 16'h0080);
              3: doc.insert(doc.size(), 16'h07FF);
              4: doc.insert(doc.size(), 16'h0800);
              default: doc.insert(doc.size(), 16'hFFFF);
            endcase
          end
        endcase
      end
      end_kind = $urandom_range(0, 9);
      no_end   = (end_kind == 0);
      sep_end  = !no_end && (doc.size() == 0 || end_kind <= 3);
      foreach (doc[i]) begin
        if ($urandom_range(0, 11) == 0) send_word(16'($urandom), 1'b0, 1'b0);
        send_word(doc[i], 1'b1, !no_end && !sep_end && (i == doc.size() - 1));
        sent++;
      end
      if (sep_end) begin
        send_word(16'($urandom), 1'b0, 1'b1);
        sent++;
      end
      if (!no_end) docs++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0] phase_modes [8];
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.code_unit    = '0;
    in_ch.unit_present = 1'b0;
    in_ch.end_of_text  = 1'b0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    errors      = 0;
    words_sent  = 0;
    bytes_seen  = 0;
    docs        = 0;
    idle_cycles = 0;
    cur_mode    = utse_pkg::MODE_UTF8;
    held_unit   = '0;
    held_ok     = 1'b0;
    doc_start   = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_utf8_ranges();
    test_lone_surrogates();
    test_marks();
    test_held_mode_switch();

    // Each idling phase runs two modes; all four modes show up twice.
    phase_modes = '{utse_pkg::MODE_UTF8, utse_pkg::MODE_UTF16BE,
                    utse_pkg::MODE_UTF8_BOM, utse_pkg::MODE_UTF16LE,
                    utse_pkg::MODE_UTF16LE, utse_pkg::MODE_UTF8,
                    utse_pkg::MODE_UTF16BE, utse_pkg::MODE_UTF8_BOM};
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int m = 0; m < 2; m++) begin
        set_mode(phase_modes[2 * p + m]);
        test_random_docs(49);
      end
    end

    wait_drained();
    $display("Ran %0d words in %0d documents, %0d bytes checked, all four modes",
             words_sent, docs, bytes_seen);
    $display("under no idling, sender idling, receiver stalls and both at once");
    if (errors == 0 && file_bytes_q.size() == 0) begin
      $display("PASS utf16_text_save_encoder_top");
    end else begin
      if (file_bytes_q.size() != 0)
        $error("out_byte: %0d expected bytes never arrived", file_bytes_q.size());
      $display("FAIL utf16_text_save_encoder_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/utse_pkg.sv
rtl/core/utse_if.sv
rtl/core/utse_front.sv
rtl/core/utse_queue.sv
rtl/core/utse_back.sv
rtl/core/utf16_text_save_encoder_top.sv
rtl/core/utse_checker.sv
test/utf16_text_save_encoder_top_tb.sv
